// ===== rtl/dmv_pkg.sv =====
package dmv_pkg;

    localparam int DEF_MAX_SIZE   = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 4;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int SIZE_W   = 5;

    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_MAT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VEC = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACC_T = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef enum logic [1:0] {
        CMD_MAT,
        CMD_VEC,
        CMD_RUN
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [INDEX_W-1:0]  row;
        logic [INDEX_W-1:0]  col;
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   addend;
        logic [MODE_W-1:0]   mode;
        logic [SIZE_W-1:0]   size;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_ROUND,
        BK_EMIT
    } t_back_state;

endpackage

// ===== rtl/dense_matrix_vector_multiply.sv =====
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  action, row, col, value, addend, op_mode
// output    out        o_out_valid / i_out_stall out_index, y_value, overflow, last
// config    in         i_cfg_wr_en              size_in_use
//
// Each load request is written into storage as the execution unit pops it from the queue.
// A compute request over n rows uses the single multiply-accumulate pipeline; it walks
// the matrix one entry per cycle within a row, then rounds and emits it, held by i_out_stall.
// Reset is synchronous and active low; it clears the matrix to zero and sets the size to 16.
// A four-entry request queue keeps the input accepting while the output stalls, until full.
module dense_matrix_vector_multiply #(
    parameter int MAX_SIZE   = dmv_pkg::DEF_MAX_SIZE,
    parameter int VALUE_BITS = dmv_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dmv_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [dmv_pkg::ACTION_W-1:0] i_action,
    input  logic [dmv_pkg::INDEX_W-1:0]  i_row,
    input  logic [dmv_pkg::INDEX_W-1:0]  i_col,
    input  logic [dmv_pkg::DATA_W-1:0]   i_value,
    input  logic [dmv_pkg::DATA_W-1:0]   i_addend,
    input  logic [dmv_pkg::MODE_W-1:0]   i_op_mode,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dmv_pkg::INDEX_W-1:0]  o_out_index,
    output logic [dmv_pkg::DATA_W-1:0]   o_y_value,
    output logic                         o_overflow,
    output logic                         o_last
);
    import dmv_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;

    dmv_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .i_addend      (i_addend),
        .i_op_mode     (i_op_mode),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    dmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    dmv_back #(
        .MAX_SIZE   (MAX_SIZE),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_index (o_out_index),
        .o_y_value   (o_y_value),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/dmv_front.sv =====
module dmv_front #(
    parameter int MAX_SIZE = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [dmv_pkg::SIZE_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [dmv_pkg::ACTION_W-1:0] i_action,
    input  logic [dmv_pkg::INDEX_W-1:0]  i_row,
    input  logic [dmv_pkg::INDEX_W-1:0]  i_col,
    input  logic [dmv_pkg::DATA_W-1:0]   i_value,
    input  logic [dmv_pkg::DATA_W-1:0]   i_addend,
    input  logic [dmv_pkg::MODE_W-1:0]   i_op_mode,
    input  logic                       i_q_full,
    output logic                       o_push,
    output dmv_pkg::t_cmd              o_cmd
);
    import dmv_pkg::*;

    localparam int LIM = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam logic [SIZE_W-1:0] LIM_S = SIZE_W'(LIM);

    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] w_n;
    logic              w_keep;
    logic              w_row_ok;
    logic              w_col_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    assign w_row_ok = SIZE_W'(i_row) < LIM_S;
    assign w_col_ok = SIZE_W'(i_col) < LIM_S;

    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > LIM_S) begin
            w_n = LIM_S;
        end else begin
            w_n = r_size;
        end
    end

    always_comb begin
        o_cmd.row    = i_row;
        o_cmd.col    = i_col;
        o_cmd.value  = i_value;
        o_cmd.addend = i_addend;
        o_cmd.mode   = i_op_mode;
        o_cmd.size   = w_n;
        case (i_action)
            ACT_MAT: begin
                o_cmd.kind = CMD_MAT;
                w_keep     = w_row_ok && w_col_ok;
            end
            ACT_VEC: begin
                o_cmd.kind = CMD_VEC;
                w_keep     = w_row_ok;
            end
            ACT_RUN: begin
                o_cmd.kind = CMD_RUN;
                w_keep     = (i_op_mode != MODE_NONE);
            end
            default: begin
                o_cmd.kind = CMD_RUN;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && w_keep;

endmodule

// ===== rtl/dmv_queue.sv =====
module dmv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dmv_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output dmv_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import dmv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/dmv_back.sv =====
module dmv_back #(
    parameter int MAX_SIZE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  dmv_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [dmv_pkg::INDEX_W-1:0] o_out_index,
    output logic [dmv_pkg::DATA_W-1:0]  o_y_value,
    output logic                        o_overflow,
    output logic                        o_last
);
    import dmv_pkg::*;

    localparam int LIM    = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int IDX_W  = $clog2(LIM);
    localparam int VDEPTH = 1 << IDX_W;
    localparam int DEPTH  = 1 << (2 * IDX_W);
    localparam int VB     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int PW     = 2 * VB;
    localparam int AW     = PW + 5;
    localparam int NW     = AW - FRAC_BITS;
    localparam int RW     = NW + 1;

    localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_MAX  = {{(RW-VB+1){1'b0}}, {(VB-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_MIN  = {{(RW-VB+1){1'b1}}, {(VB-1){1'b0}}};

    t_back_state r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W:0]    r_j, n_j;
    logic [IDX_W:0]    r_n, n_n;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_s1_valid, r_s1_last;
    logic              r_s2_valid, r_s2_last;
    logic              r_out_valid, n_out_valid;
    logic [DEPTH-1:0]  r_mvalid;

    logic [VB-1:0]        r_mem [DEPTH];
    logic signed [VB-1:0] r_x [VDEPTH];
    logic signed [VB-1:0] r_y [VDEPTH];
    logic signed [VB-1:0] r_m_rd;
    logic                 r_mv_rd;
    logic signed [VB-1:0] r_x_rd;
    logic signed [VB-1:0] r_y_rd;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [NW-1:0] r_rnd;
    logic [IDX_W-1:0]     r_out_idx;
    logic signed [VB-1:0] r_out_y;
    logic                 r_out_ovf;
    logic                 r_out_last;

    logic                  w_issue;
    logic                  w_emit;
    logic                  w_acc_clr;
    logic                  w_mat_wr;
    logic                  w_vec_wr;
    logic                  w_last_row;
    logic                  w_last_col;
    logic [IDX_W-1:0]      w_jx;
    logic [2*IDX_W-1:0]    w_rd_addr;
    logic [2*IDX_W-1:0]    w_wr_addr;
    logic signed [VB-1:0]  w_m_eff;
    logic signed [PW-1:0]  w_prod;
    logic signed [AW-1:0]  w_rnd_full;
    logic signed [RW-1:0]  w_sum;
    logic signed [VB-1:0]  w_sat;
    logic                  w_ovf;

    assign w_jx       = r_j[IDX_W-1:0];
    assign w_last_row = (({1'b0, r_i}) + 1'b1) == r_n;
    assign w_last_col = (r_j + 1'b1) == r_n;
    assign w_rd_addr  = (r_mode == MODE_ACC_T) ? {w_jx, r_i} : {r_i, w_jx};
    assign w_wr_addr  = {i_cmd.row[IDX_W-1:0], i_cmd.col[IDX_W-1:0]};
    assign w_mat_wr   = o_pop && (i_cmd.kind == CMD_MAT);
    assign w_vec_wr   = o_pop && (i_cmd.kind == CMD_VEC);

    assign w_m_eff    = r_mv_rd ? r_m_rd : '0;
    assign w_prod     = w_m_eff * r_x_rd;
    assign w_rnd_full = r_acc + RND_HALF;
    assign w_sum      = RW'(r_rnd) + ((r_mode != MODE_SET) ? RW'(r_y_rd) : RW'(0));

    always_comb begin
        if (w_sum > SAT_MAX) begin
            w_sat = SAT_MAX[VB-1:0];
            w_ovf = 1'b1;
        end else if (w_sum < SAT_MIN) begin
            w_sat = SAT_MIN[VB-1:0];
            w_ovf = 1'b1;
        end else begin
            w_sat = w_sum[VB-1:0];
            w_ovf = 1'b0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_mode    = r_mode;
        o_pop     = 1'b0;
        w_issue   = 1'b0;
        w_emit    = 1'b0;
        w_acc_clr = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_RUN) begin
                        n_state   = BK_MAC;
                        n_mode    = i_cmd.mode;
                        n_n       = i_cmd.size[IDX_W:0];
                        n_i       = '0;
                        n_j       = '0;
                        w_acc_clr = 1'b1;
                    end
                end
            end
            BK_MAC: begin
                if (r_j < r_n) begin
                    w_issue = 1'b1;
                    n_j     = r_j + 1'b1;
                end
                if (r_s2_valid && r_s2_last) begin
                    n_state = BK_ROUND;
                end
            end
            BK_ROUND: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_emit = 1'b1;
                    if (w_last_row) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_state   = BK_MAC;
                        n_i       = r_i + 1'b1;
                        n_j       = '0;
                        w_acc_clr = 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        n_out_valid = w_emit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_mode      <= MODE_SET;
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_last   <= 1'b0;
            r_out_valid <= 1'b0;
            r_mvalid    <= '0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_mode      <= n_mode;
            r_s1_valid  <= w_issue;
            r_s1_last   <= w_issue && w_last_col;
            r_s2_valid  <= r_s1_valid;
            r_s2_last   <= r_s1_last;
            r_out_valid <= n_out_valid;
            if (w_mat_wr) begin
                r_mvalid[w_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mat_wr) begin
            r_mem[w_wr_addr] <= i_cmd.value[VB-1:0];
        end
        r_m_rd  <= r_mem[w_rd_addr];
        r_mv_rd <= r_mvalid[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_vec_wr) begin
            r_x[i_cmd.row[IDX_W-1:0]] <= i_cmd.value[VB-1:0];
            r_y[i_cmd.row[IDX_W-1:0]] <= i_cmd.addend[VB-1:0];
        end else if (w_emit) begin
            r_y[r_i] <= w_sat;
        end
        r_x_rd <= r_x[w_jx];
        r_prod <= w_prod;
        if (w_acc_clr) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            r_acc <= r_acc + AW'(r_prod);
        end
        if (r_state == BK_ROUND) begin
            r_rnd  <= w_rnd_full[AW-1:FRAC_BITS];
            r_y_rd <= r_y[r_i];
        end
        if (w_emit) begin
            r_out_idx  <= r_i;
            r_out_y    <= w_sat;
            r_out_ovf  <= w_ovf;
            r_out_last <= w_last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = INDEX_W'(r_out_idx);
    assign o_y_value   = DATA_W'(r_out_y);
    assign o_overflow  = r_out_ovf;
    assign o_last      = r_out_last;

endmodule
